@@ rtl/ubie_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and helpers for the buffered uart interrupt engine
// no dependencies

package ubie_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int NUM_STATS  = 6;
  localparam int STAT_SEL_W = 3;
  localparam int STAT_W     = 32;
  localparam int BURST_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [BURST_W-1:0] BURST_MAX = 5'd16;
  localparam logic [BURST_W-1:0] BURST_MIN = 5'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_OPEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_BURST  = 1'd1;

  localparam logic [2:0] MODE_HOST_WR  = 3'd0;
  localparam logic [2:0] MODE_HOST_RD  = 3'd1;
  localparam logic [2:0] MODE_LINE_RX  = 3'd2;
  localparam logic [2:0] MODE_LINE_ST  = 3'd3;
  localparam logic [2:0] MODE_TX_READY = 3'd4;

  localparam int STAT_TX_BYTES = 0;
  localparam int STAT_RX_BYTES = 1;
  localparam int STAT_OVERRUN  = 2;
  localparam int STAT_PARITY   = 3;
  localparam int STAT_FRAMING  = 4;
  localparam int STAT_BREAK    = 5;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GAP
  } state_t;

  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_adv = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/uart_buffered_interrupt_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// buffered uart interrupt engine: tx and rx rings in synchronous memories,
// statistics counters and a transmitter drain sequencer; uses ubie_pkg
//
// channel  dir  handshake              payload
// in_      in   in_valid / in_ready    in_mode, in_data_byte, in_line_status, in_stat_select
// out_     out  out_valid / out_ready  out_read_byte .. out_stat_value, out_last
// cfg_     in   cfg_wr_en              cfg_index, cfg_wdata
//
// modes 0..3 and a ready event that sends nothing: each item passes through accept (idle) and execute
// a ready event sending n bytes: execute and gap alternate, one byte per memory read turn of the tx ring
// in_ready is high only while idle; an item waits in execute while the output beat stalls
// synchronous active-low reset clears pointers, counters and control; no clearing pass

module uart_buffered_interrupt_engine_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [2:0]                        in_mode,
  input  wire  [7:0]                        in_data_byte,
  input  wire  [3:0]                        in_line_status,
  input  wire  [ubie_pkg::STAT_SEL_W-1:0]   in_stat_select,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [7:0]                        out_read_byte,
  output logic                              out_read_ok,
  output logic                              out_write_ok,
  output logic [7:0]                        out_line_byte,
  output logic                              out_line_byte_valid,
  output logic                              out_last,
  output logic                              out_tx_irq_enable,
  output logic                              out_rx_not_empty,
  output logic [ubie_pkg::STAT_W-1:0]       out_stat_value,
  input  wire                               cfg_wr_en,
  input  wire  [ubie_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ubie_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  ubie_pkg::state_t state_r, state_nxt;

  logic [7:0] tx_mem [ubie_pkg::RING_DEPTH];
  logic [7:0] rx_mem [ubie_pkg::RING_DEPTH];
  logic [7:0] tx_rdata_r, rx_rdata_r;
  logic       tx_we, rx_we;

  ubie_pkg::ptr_t tx_wr_ptr_r, tx_wr_ptr_nxt, tx_rd_ptr_r, tx_rd_ptr_nxt;
  ubie_pkg::ptr_t rx_wr_ptr_r, rx_wr_ptr_nxt, rx_rd_ptr_r, rx_rd_ptr_nxt;

  logic [ubie_pkg::STAT_W-1:0] stat_cnt_r   [ubie_pkg::NUM_STATS];
  logic [ubie_pkg::STAT_W-1:0] stat_cnt_nxt [ubie_pkg::NUM_STATS];

  logic                          tx_irq_on_r, tx_irq_on_nxt;
  logic                          port_open_r;
  logic [ubie_pkg::BURST_W-1:0]  tx_burst_r;
  logic [ubie_pkg::BURST_W-1:0]  burst_lim;
  logic [ubie_pkg::BURST_W-1:0]  drain_cnt_r, drain_cnt_nxt;

  logic [2:0]                      mode_r, mode_nxt;
  logic [7:0]                      data_r, data_nxt;
  logic [3:0]                      ls_r, ls_nxt;
  logic [ubie_pkg::STAT_SEL_W-1:0] sel_r, sel_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_rb_r, out_rb_nxt;
  logic                        out_rok_r, out_rok_nxt;
  logic                        out_wok_r, out_wok_nxt;
  logic [7:0]                  out_lb_r, out_lb_nxt;
  logic                        out_lbv_r, out_lbv_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_irq_r, out_irq_nxt;
  logic                        out_rxne_r, out_rxne_nxt;
  logic [ubie_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign burst_lim = (tx_burst_r == '0) ? ubie_pkg::BURST_MIN :
                     (tx_burst_r > ubie_pkg::BURST_MAX) ? ubie_pkg::BURST_MAX : tx_burst_r;

  // ring memories, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr_ptr_r] <= data_r;
    end
    tx_rdata_r <= tx_mem[tx_rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr_ptr_r] <= data_r;
    end
    rx_rdata_r <= rx_mem[rx_rd_ptr_r];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_open_r <= 1'b0;
      tx_burst_r  <= ubie_pkg::BURST_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ubie_pkg::CFG_PORT_OPEN: port_open_r <= cfg_wdata[0];
        ubie_pkg::CFG_TX_BURST:  tx_burst_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ubie_pkg::ST_IDLE;
      tx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      tx_irq_on_r <= 1'b0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ubie_pkg::NUM_STATS; i++) begin
        stat_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      tx_wr_ptr_r <= tx_wr_ptr_nxt;
      tx_rd_ptr_r <= tx_rd_ptr_nxt;
      rx_wr_ptr_r <= rx_wr_ptr_nxt;
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      tx_irq_on_r <= tx_irq_on_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < ubie_pkg::NUM_STATS; i++) begin
        stat_cnt_r[i] <= stat_cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    data_r     <= data_nxt;
    ls_r       <= ls_nxt;
    sel_r      <= sel_nxt;
    out_rb_r   <= out_rb_nxt;
    out_rok_r  <= out_rok_nxt;
    out_wok_r  <= out_wok_nxt;
    out_lb_r   <= out_lb_nxt;
    out_lbv_r  <= out_lbv_nxt;
    out_last_r <= out_last_nxt;
    out_irq_r  <= out_irq_nxt;
    out_rxne_r <= out_rxne_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    logic drained;
    logic fin;
    logic [ubie_pkg::BURST_W-1:0] sent;
    state_nxt     = state_r;
    tx_wr_ptr_nxt = tx_wr_ptr_r;
    tx_rd_ptr_nxt = tx_rd_ptr_r;
    rx_wr_ptr_nxt = rx_wr_ptr_r;
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    tx_irq_on_nxt = tx_irq_on_r;
    drain_cnt_nxt = drain_cnt_r;
    for (int i = 0; i < ubie_pkg::NUM_STATS; i++) begin
      stat_cnt_nxt[i] = stat_cnt_r[i];
    end
    tx_we         = 1'b0;
    rx_we         = 1'b0;
    mode_nxt      = mode_r;
    data_nxt      = data_r;
    ls_nxt        = ls_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rb_nxt    = out_rb_r;
    out_rok_nxt   = out_rok_r;
    out_wok_nxt   = out_wok_r;
    out_lb_nxt    = out_lb_r;
    out_lbv_nxt   = out_lbv_r;
    out_last_nxt  = out_last_r;
    out_irq_nxt   = out_irq_r;
    out_rxne_nxt  = out_rxne_r;
    out_stat_nxt  = out_stat_r;
    in_ready      = 1'b0;
    drained       = 1'b0;
    fin           = 1'b1;
    sent          = drain_cnt_r + ubie_pkg::BURST_W'(1);

    case (state_r)
      ubie_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt      = in_mode;
          data_nxt      = in_data_byte;
          ls_nxt        = in_line_status;
          sel_nxt       = in_stat_select;
          drain_cnt_nxt = '0;
          state_nxt     = ubie_pkg::ST_EXEC;
        end
      end
      ubie_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt   = ubie_pkg::ST_IDLE;
          out_rb_nxt  = 8'd0;
          out_rok_nxt = 1'b0;
          out_wok_nxt = 1'b0;
          out_lb_nxt  = 8'd0;
          out_lbv_nxt = 1'b0;
          if (port_open_r) begin
            case (mode_r)
              ubie_pkg::MODE_HOST_WR: begin
                if (ubie_pkg::ptr_adv(tx_wr_ptr_r) != tx_rd_ptr_r) begin
                  tx_we         = 1'b1;
                  tx_wr_ptr_nxt = ubie_pkg::ptr_adv(tx_wr_ptr_r);
                  out_wok_nxt   = 1'b1;
                  tx_irq_on_nxt = 1'b1;
                  stat_cnt_nxt[ubie_pkg::STAT_TX_BYTES] =
                    stat_cnt_r[ubie_pkg::STAT_TX_BYTES] + 32'd1;
                end
              end
              ubie_pkg::MODE_HOST_RD: begin
                if (rx_wr_ptr_r != rx_rd_ptr_r) begin
                  out_rb_nxt    = rx_rdata_r;
                  out_rok_nxt   = 1'b1;
                  rx_rd_ptr_nxt = ubie_pkg::ptr_adv(rx_rd_ptr_r);
                end
              end
              ubie_pkg::MODE_LINE_RX: begin
                if (ubie_pkg::ptr_adv(rx_wr_ptr_r) != rx_rd_ptr_r) begin
                  rx_we         = 1'b1;
                  rx_wr_ptr_nxt = ubie_pkg::ptr_adv(rx_wr_ptr_r);
                  stat_cnt_nxt[ubie_pkg::STAT_RX_BYTES] =
                    stat_cnt_r[ubie_pkg::STAT_RX_BYTES] + 32'd1;
                end else begin
                  stat_cnt_nxt[ubie_pkg::STAT_OVERRUN] =
                    stat_cnt_r[ubie_pkg::STAT_OVERRUN] + 32'd1;
                end
              end
              ubie_pkg::MODE_LINE_ST: begin
                stat_cnt_nxt[ubie_pkg::STAT_OVERRUN] =
                  stat_cnt_r[ubie_pkg::STAT_OVERRUN] + 32'(ls_r[0]);
                stat_cnt_nxt[ubie_pkg::STAT_PARITY] =
                  stat_cnt_r[ubie_pkg::STAT_PARITY] + 32'(ls_r[1]);
                stat_cnt_nxt[ubie_pkg::STAT_FRAMING] =
                  stat_cnt_r[ubie_pkg::STAT_FRAMING] + 32'(ls_r[2]);
                stat_cnt_nxt[ubie_pkg::STAT_BREAK] =
                  stat_cnt_r[ubie_pkg::STAT_BREAK] + 32'(ls_r[3]);
              end
              ubie_pkg::MODE_TX_READY: begin
                if (tx_wr_ptr_r != tx_rd_ptr_r) begin
                  out_lb_nxt    = tx_rdata_r;
                  out_lbv_nxt   = 1'b1;
                  tx_rd_ptr_nxt = ubie_pkg::ptr_adv(tx_rd_ptr_r);
                  drain_cnt_nxt = sent;
                  drained       = (ubie_pkg::ptr_adv(tx_rd_ptr_r) == tx_wr_ptr_r);
                  fin           = drained || (sent == burst_lim);
                  if (drained) begin
                    tx_irq_on_nxt = 1'b0;
                  end
                  if (!fin) begin
                    state_nxt = ubie_pkg::ST_GAP;
                  end
                end else begin
                  tx_irq_on_nxt = 1'b0;
                end
              end
              default: ;
            endcase
          end
          out_valid_nxt = 1'b1;
          out_last_nxt  = fin;
          out_irq_nxt   = fin ? tx_irq_on_nxt : tx_irq_on_r;
          out_rxne_nxt  = (rx_wr_ptr_nxt != rx_rd_ptr_nxt);
          out_stat_nxt  = (sel_r < 3'(ubie_pkg::NUM_STATS)) ?
                          stat_cnt_nxt[sel_r] : '0;
        end
      end
      ubie_pkg::ST_GAP: begin
        // tx read data refreshes for the next byte
        state_nxt = ubie_pkg::ST_EXEC;
      end
      default: begin
        state_nxt = ubie_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_read_byte       = out_rb_r;
  assign out_read_ok         = out_rok_r;
  assign out_write_ok        = out_wok_r;
  assign out_line_byte       = out_lb_r;
  assign out_line_byte_valid = out_lbv_r;
  assign out_last            = out_last_r;
  assign out_tx_irq_enable   = out_irq_r;
  assign out_rx_not_empty    = out_rxne_r;
  assign out_stat_value      = out_stat_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_wr_ptr_r <= ubie_pkg::PTR_W'(ubie_pkg::RING_DEPTH - 1)) &&
    (rx_wr_ptr_r <= ubie_pkg::PTR_W'(ubie_pkg::RING_DEPTH - 1)))
    else $error("ring write pointer out of range");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ubie_pkg::ST_IDLE) |-> (drain_cnt_r <= burst_lim))
    else $error("drain sent more bytes than the burst limit");

  a_irq_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(tx_irq_on_r) |-> (tx_wr_ptr_r == tx_rd_ptr_r))
    else $error("tx interrupt enable cleared with bytes still queued");

  a_midburst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !out_last_nxt && state_r == ubie_pkg::ST_EXEC && out_free)
      |=> (state_r == ubie_pkg::ST_GAP))
    else $error("non-final beat issued without continuing the drain");

  a_lbv_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ubie_pkg::ST_EXEC && out_free && out_lbv_nxt)
      |-> (mode_r == ubie_pkg::MODE_TX_READY && port_open_r))
    else $error("line byte issued outside a transmitter ready event");

endmodule

`default_nettype wire
